### sv/sbnc_pkg.sv
// Shared types, widths and constants for the spectrum bin to note/color pipeline.
// Holds the elaboration-time log2 helper used for the fraction table and log2(440).
// No dependencies.
package sbnc_pkg;

  localparam int BIN_W       = 13;   // bin_index
  localparam int BINS_W      = 14;   // bin_count register
  localparam int RATE_W      = 18;   // sample_rate register
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 40;

  localparam int VAL_W   = 31;       // k * rate and 2 * bins
  localparam int E_W     = 5;        // leading-one position
  localparam int LOG_FB  = 24;       // log fraction bits
  localparam int LG_W    = E_W + LOG_FB;
  localparam int N_W     = 36;       // note with LOG_FB fraction bits
  localparam int Q_W     = N_W - LOG_FB;
  localparam int S_W     = 28;       // note modulo 12, LOG_FB fraction bits
  localparam int FOLD_W  = 27;       // distance on the 12-note circle
  localparam int MN_W    = 26;       // distance to nearest multiple of 4
  localparam int NOTE_W  = 16;
  localparam int COLOR_W = 8;

  localparam int NOTE_FRAC_BITS_DEF  = 8;
  localparam int LOG_TABLE_DEPTH_DEF = 256;

  localparam logic [BINS_W-1:0] BIN_COUNT_RST   = 14'd512;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 18'd44100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BIN_COUNT   = 2'd0,
    CFG_SAMPLE_RATE = 2'd1
  } cfg_reg_t;

  // zero frequency / infinite frequency markers
  typedef enum logic [1:0] {
    SPEC_NONE = 2'd0,
    SPEC_ZERO = 2'd1,
    SPEC_INF  = 2'd2
  } spec_t;

  typedef struct packed {
    logic enc;    // leading-one search
    logic norm;   // normalize and form table index
    logic look;   // table read
  } log_adv_t;

  typedef struct packed {
    logic note;   // rounding, saturation, modulo 12
    logic fold;   // circle distances
    logic lvl;    // color levels
  } color_adv_t;

  // log2 of a Q1.30 value in [1,2), LOG_FB fraction bits, by repeated squaring
  function automatic logic [LOG_FB-1:0] frac_log(input longint unsigned m_in);
    longint unsigned m;
    logic [LOG_FB-1:0] r;
    m = m_in;
    r = '0;
    for (int b = 0; b < LOG_FB; b++) begin
      m = (m * m) >> 30;
      r = {r[LOG_FB-2:0], 1'b0};
      if (m >= 64'h0000_0000_8000_0000) begin
        m = m >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam logic [LG_W-1:0] LOG2_440 =
    LG_W'((longint'(8) << LOG_FB) + longint'(frac_log(64'd440 << 22)));

  localparam logic signed [N_W-1:0] NOTE_BASE = N_W'(longint'(57) << LOG_FB);

endpackage

### sv/sbnc_log2.sv
// Three-stage fixed-point log2: leading-one search, normalize to a table index,
// fraction table read. Result is e.frac with LOG_FB fraction bits.
// Depends on sbnc_pkg.
module sbnc_log2 #(
  parameter int LOG_TABLE_DEPTH = sbnc_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  sbnc_pkg::log_adv_t            adv,
  input  logic [sbnc_pkg::VAL_W-1:0]    val,
  output logic [sbnc_pkg::LG_W-1:0]     lg
);

  localparam int IW = $clog2(LOG_TABLE_DEPTH);
  localparam int PW = (sbnc_pkg::VAL_W - 1) + IW;

  logic [sbnc_pkg::LOG_FB-1:0] rom [LOG_TABLE_DEPTH];

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned M =
      ((longint'(LOG_TABLE_DEPTH) + longint'(g)) << 30) / LOG_TABLE_DEPTH;
    assign rom[g] = sbnc_pkg::frac_log(M);
  end

  logic [sbnc_pkg::E_W-1:0]   e_next;
  logic [sbnc_pkg::VAL_W-1:0] va;
  logic [sbnc_pkg::E_W-1:0]   ea;
  logic [sbnc_pkg::VAL_W-1:0] shl;
  logic [PW-1:0]              prod;
  logic [IW-1:0]              idx;
  logic [sbnc_pkg::E_W-1:0]   eb;

  always_comb begin
    e_next = '0;
    for (int b = 0; b < sbnc_pkg::VAL_W; b++) begin
      if (val[b]) begin
        e_next = sbnc_pkg::E_W'(b);
      end
    end
  end

  // leading one moved to bit 30 and dropped: Q0.30 mantissa fraction
  always_comb begin
    shl  = va << (sbnc_pkg::E_W'(sbnc_pkg::VAL_W - 1) - ea);
    prod = PW'(shl[sbnc_pkg::VAL_W-2:0]) * PW'(LOG_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (adv.enc) begin
      va <= val;
      ea <= e_next;
    end
    if (adv.norm) begin
      idx <= prod[PW-1 -: IW];
      eb  <= ea;
    end
    if (adv.look) begin
      lg <= {eb, rom[idx]};
    end
  end

endmodule

### sv/sbnc_color.sv
// Back three stages: note rounding/saturation and modulo 12, circle distances,
// color levels with the zero/infinite frequency override.
// Depends on sbnc_pkg.
module sbnc_color #(
  parameter int NOTE_FRAC_BITS = sbnc_pkg::NOTE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  sbnc_pkg::color_adv_t                adv,
  input  logic signed [sbnc_pkg::N_W-1:0]     n,
  input  sbnc_pkg::spec_t                     spec,
  output logic [sbnc_pkg::NOTE_W-1:0]         note,
  output logic [sbnc_pkg::COLOR_W-1:0]        red,
  output logic [sbnc_pkg::COLOR_W-1:0]        green,
  output logic [sbnc_pkg::COLOR_W-1:0]        blue
);

  localparam int SH = sbnc_pkg::LOG_FB - NOTE_FRAC_BITS;
  localparam logic signed [sbnc_pkg::N_W-1:0] HALF     = sbnc_pkg::N_W'(1) <<< (SH - 1);
  localparam logic signed [sbnc_pkg::N_W-1:0] NOTE_MAX = sbnc_pkg::N_W'(32767);
  localparam logic signed [sbnc_pkg::N_W-1:0] NOTE_MIN = -NOTE_MAX - sbnc_pkg::N_W'(1);
  localparam logic [sbnc_pkg::S_W:0] ONE  = (sbnc_pkg::S_W + 1)'(1) << sbnc_pkg::LOG_FB;
  localparam logic [sbnc_pkg::S_W:0] PER  = (sbnc_pkg::S_W + 1)'(12) << sbnc_pkg::LOG_FB;
  localparam logic [sbnc_pkg::S_W:0] SIX_NOTES = (sbnc_pkg::S_W + 1)'(6) << sbnc_pkg::LOG_FB;
  localparam logic [sbnc_pkg::S_W:0] TEN_NOTES = (sbnc_pkg::S_W + 1)'(10) << sbnc_pkg::LOG_FB;
  localparam logic [sbnc_pkg::MN_W:0] PER4 = (sbnc_pkg::MN_W + 1)'(1) << sbnc_pkg::MN_W;

  // distance from the nearest multiple of 12 notes, u below 24 notes
  function automatic logic [sbnc_pkg::FOLD_W-1:0] fold12(input logic [sbnc_pkg::S_W:0] u);
    logic [sbnc_pkg::S_W:0] w;
    logic [sbnc_pkg::S_W:0] c;
    w = (u >= PER) ? u - PER : u;
    c = PER - w;
    return sbnc_pkg::FOLD_W'((w < c) ? w : c);
  endfunction

  function automatic logic [sbnc_pkg::COLOR_W-1:0] level(
    input logic [sbnc_pkg::FOLD_W-1:0] t,
    input logic [sbnc_pkg::MN_W-1:0]   m
  );
    logic signed [sbnc_pkg::FOLD_W:0] d;
    logic [sbnc_pkg::N_W-1:0]         dd;
    logic [sbnc_pkg::N_W-1:0]         p;
    logic [sbnc_pkg::N_W-1:0]         v;
    d  = $signed({1'b0, t}) - $signed({2'b00, m});
    dd = sbnc_pkg::N_W'(d[sbnc_pkg::FOLD_W-1:0]);
    p  = (dd << 8) - dd + (sbnc_pkg::N_W'(1) << 25);   // d*255 rounded at bit 26
    v  = p >> 26;
    if (d < 0) begin
      return '0;
    end else if (v > sbnc_pkg::N_W'(255)) begin
      return '1;
    end else begin
      return v[sbnc_pkg::COLOR_W-1:0];
    end
  endfunction

  // note stage
  logic signed [sbnc_pkg::N_W-1:0] n_rnd;
  logic signed [sbnc_pkg::N_W-1:0] n_sh;
  logic [sbnc_pkg::NOTE_W-1:0]     note_next;
  logic [sbnc_pkg::Q_W-1:0]        x;
  logic [21:0]                     qp;
  logic [7:0]                      q12;
  logic [sbnc_pkg::Q_W-1:0]        rem;
  logic [sbnc_pkg::NOTE_W-1:0]     note_a;
  logic [sbnc_pkg::S_W-1:0]        s;
  sbnc_pkg::spec_t                 spec_a;

  always_comb begin
    n_rnd = n + HALF;
    n_sh  = n_rnd >>> SH;
    if (n_sh > NOTE_MAX) begin
      note_next = 16'h7FFF;
    end else if (n_sh < NOTE_MIN) begin
      note_next = 16'h8000;
    end else begin
      note_next = n_sh[sbnc_pkg::NOTE_W-1:0];
    end
    // integer part plus 64 periods is positive and below 2048, so x*683>>13 is x/12
    x   = n[sbnc_pkg::N_W-1:sbnc_pkg::LOG_FB] + sbnc_pkg::Q_W'(768);
    qp  = {10'd0, x} * 22'd683;
    q12 = qp[20:13];
    rem = x - sbnc_pkg::Q_W'({q12, 3'b000}) - sbnc_pkg::Q_W'({q12, 2'b00});
  end

  // circle distance stage
  logic [sbnc_pkg::S_W:0]        se;
  logic [sbnc_pkg::S_W:0]        um;
  logic [sbnc_pkg::MN_W:0]       cm;
  logic [sbnc_pkg::MN_W-1:0]     mn_next;
  logic [sbnc_pkg::FOLD_W-1:0]   fr;
  logic [sbnc_pkg::FOLD_W-1:0]   fg;
  logic [sbnc_pkg::FOLD_W-1:0]   fb;
  logic [sbnc_pkg::MN_W-1:0]     mn;
  logic [sbnc_pkg::NOTE_W-1:0]   note_b;
  sbnc_pkg::spec_t               spec_b;

  always_comb begin
    se = {1'b0, s};
    um = se + (ONE << 1);
    cm = PER4 - {1'b0, um[sbnc_pkg::MN_W-1:0]};
    mn_next = ({1'b0, um[sbnc_pkg::MN_W-1:0]} < cm) ? um[sbnc_pkg::MN_W-1:0]
                                                    : cm[sbnc_pkg::MN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv.note) begin
      note_a <= note_next;
      s      <= {rem[3:0], n[sbnc_pkg::LOG_FB-1:0]};
      spec_a <= spec;
    end
    if (adv.fold) begin
      fr     <= fold12(se + SIX_NOTES);
      fg     <= fold12(se + (ONE << 1));
      fb     <= fold12(se + TEN_NOTES);
      mn     <= mn_next;
      note_b <= note_a;
      spec_b <= spec_a;
    end
    if (adv.lvl) begin
      case (spec_b)
        sbnc_pkg::SPEC_ZERO: begin
          note  <= 16'h8000;
          red   <= '0;
          green <= '0;
          blue  <= '0;
        end
        sbnc_pkg::SPEC_INF: begin
          note  <= 16'h7FFF;
          red   <= '0;
          green <= '0;
          blue  <= '0;
        end
        default: begin
          note  <= note_b;
          red   <= level(fr, mn);
          green <= level(fg, mn);
          blue  <= level(fb, mn);
        end
      endcase
    end
  end

endmodule

### sv/spectrum_bin_to_note_color.sv
// Top level: spectrum bin index to note number (signed Q8.8) and RGB color.
// Depends on sbnc_pkg, sbnc_log2, sbnc_color.
//
//   port group  dir   word                                      handshake
//   s_*         in    tdata[12:0] bin_index                     s_tvalid/s_tready
//   m_*         out   tdata note_fixed, red, green, blue        m_tvalid/m_tready
//   cfg_*       in    cfg_index register, cfg_data value        cfg_valid/cfg_ready
//
// Eight register stages: multiply, leading-one search, normalize, table read,
// note sum, round/modulo 12, circle distances, levels. One word per cycle sustained
// while m_tready is high. rst clears the valid bits and sets the two config registers
// to their defaults; the log tables are constants, so there is no clearing pass. Each
// stage holds only while it is full and the stage after it holds, so bubbles close up
// under a stall on m_tready and nothing is dropped or repeated.
module spectrum_bin_to_note_color #(
  parameter int NOTE_FRAC_BITS  = sbnc_pkg::NOTE_FRAC_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = sbnc_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sbnc_pkg::S_TDATA_W-1:0]     s_tdata,    // [12:0] bin_index
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sbnc_pkg::M_TDATA_W-1:0]     m_tdata,    // [15:0] note_fixed, [23:16] red,
                                                         // [31:24] green, [39:32] blue
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbnc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sbnc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NS = 8;

  logic [sbnc_pkg::BINS_W-1:0] bin_count;
  logic [sbnc_pkg::RATE_W-1:0] sample_rate;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count   <= sbnc_pkg::BIN_COUNT_RST;
      sample_rate <= sbnc_pkg::SAMPLE_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbnc_pkg::CFG_BIN_COUNT:   bin_count   <= cfg_data[sbnc_pkg::BINS_W-1:0];
        sbnc_pkg::CFG_SAMPLE_RATE: sample_rate <= cfg_data[sbnc_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 0: numerator and denominator of the bin frequency
  logic [sbnc_pkg::BIN_W-1:0] bin_index;
  logic [sbnc_pkg::VAL_W-1:0] num;
  logic [sbnc_pkg::VAL_W-1:0] den;
  sbnc_pkg::spec_t            spec_in;
  sbnc_pkg::spec_t            spec_q [5];

  assign bin_index = s_tdata[sbnc_pkg::BIN_W-1:0];

  always_comb begin
    if (bin_index == '0 || sample_rate == '0) begin
      spec_in = sbnc_pkg::SPEC_ZERO;
    end else if (bin_count == '0) begin
      spec_in = sbnc_pkg::SPEC_INF;
    end else begin
      spec_in = sbnc_pkg::SPEC_NONE;
    end
  end

  // special-case markers ride along through stage 4
  always_ff @(posedge clk) begin
    if (en[0]) begin
      num       <= sbnc_pkg::VAL_W'(bin_index) * sbnc_pkg::VAL_W'(sample_rate);
      den       <= sbnc_pkg::VAL_W'({bin_count, 1'b0});
      spec_q[0] <= spec_in;
    end
    for (int i = 1; i < 5; i++) begin
      if (en[i]) begin
        spec_q[i] <= spec_q[i-1];
      end
    end
  end

  // stages 1-3: two log2 units side by side
  sbnc_pkg::log_adv_t         log_adv;
  logic [sbnc_pkg::LG_W-1:0]  lnum;
  logic [sbnc_pkg::LG_W-1:0]  lden;

  assign log_adv = '{enc: en[1], norm: en[2], look: en[3]};

  sbnc_log2 #(
    .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
  ) u_log_num (
    .clk(clk),
    .adv(log_adv),
    .val(num),
    .lg (lnum)
  );

  sbnc_log2 #(
    .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
  ) u_log_den (
    .clk(clk),
    .adv(log_adv),
    .val(den),
    .lg (lden)
  );

  // stage 4: N = 12 * (log2 num - log2 den - log2 440) + 57
  logic signed [sbnc_pkg::LG_W+1:0] diff;
  logic signed [sbnc_pkg::N_W-1:0]  dx;
  logic signed [sbnc_pkg::N_W-1:0]  n_next;
  logic signed [sbnc_pkg::N_W-1:0]  n_q;

  always_comb begin
    diff   = $signed({2'b00, lnum}) - $signed({2'b00, lden})
           - $signed({2'b00, sbnc_pkg::LOG2_440});
    dx     = {{(sbnc_pkg::N_W - sbnc_pkg::LG_W - 2){diff[sbnc_pkg::LG_W+1]}}, diff};
    n_next = (dx <<< 3) + (dx <<< 2) + sbnc_pkg::NOTE_BASE;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      n_q <= n_next;
    end
  end

  // stages 5-7
  sbnc_pkg::color_adv_t          color_adv;
  logic [sbnc_pkg::NOTE_W-1:0]   note_fixed;
  logic [sbnc_pkg::COLOR_W-1:0]  red;
  logic [sbnc_pkg::COLOR_W-1:0]  green;
  logic [sbnc_pkg::COLOR_W-1:0]  blue;

  assign color_adv = '{note: en[5], fold: en[6], lvl: en[7]};

  sbnc_color #(
    .NOTE_FRAC_BITS(NOTE_FRAC_BITS)
  ) u_color (
    .clk  (clk),
    .adv  (color_adv),
    .n    (n_q),
    .spec (spec_q[4]),
    .note (note_fixed),
    .red  (red),
    .green(green),
    .blue (blue)
  );

  assign m_tdata = {blue, green, red, note_fixed};

  // input side only backs up when every stage is full and the output is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> ((&vld) && !m_tready))
    else $error("input stalled with a bubble in the pipeline");

  // words in flight change only by accepts and deliveries
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) == $past($countones(vld))
                                 + int'($past(s_tvalid && s_tready))
                                 - int'($past(m_tvalid && m_tready))))
    else $error("word lost or duplicated in pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
